FILE: hdl/p_median_cost_evaluator_unit_assert.svh
// Assertion macros for the median cost evaluator.
// Included by the top level; empty bodies when SYNTHESIS is defined.
`ifndef P_MEDIAN_COST_EVALUATOR_UNIT_ASSERT_SVH
`define P_MEDIAN_COST_EVALUATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define PMCE_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("pmce assertion failed");
`define PMCE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pmce assertion failed");
`else
`define PMCE_ASSERT_ALWAYS(lbl, cond)
`define PMCE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: hdl/pmce_pkg.sv
// Shared types and constants of the median cost evaluator.
// No dependencies; imported by the sequencer, the datapath and the top level.
`default_nettype none
package pmce_pkg;

  localparam int ACT_W      = 2;
  localparam int CUST_W     = 8;
  localparam int FAC_W      = 8;
  localparam int SLOT_W     = 4;
  localparam int DIST_W     = 24;
  localparam int WGT_W      = 16;
  localparam int PROD_W     = DIST_W + WGT_W;
  localparam int COST_W     = 48;
  localparam int NC_W       = 9;
  localparam int NM_W       = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [ACT_W-1:0] ACT_LOAD_DIST   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD_WEIGHT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_LOAD_MEDIAN = 2'd2;
  localparam logic [ACT_W-1:0] ACT_EVAL        = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CUSTOMERS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_MEDIANS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_WEIGHTS   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } tag_t;

endpackage
`default_nettype wire

FILE: hdl/pmce_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module pmce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                                      clk,
  input  wire                                      wr_en,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire  [WIDTH-1:0]                         wr_data,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule
`default_nettype wire

FILE: hdl/pmce_seq.sv
// Sequencer: walks customer by median slot, holds the result register.
// Depends on pmce_pkg.
`default_nettype none
module pmce_seq #(
  parameter int MAX_CUSTOMERS = 256,
  parameter int MAX_MEDIANS   = 16
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  start,
  input  wire  [pmce_pkg::NC_W-1:0]            num_customers,
  input  wire  [pmce_pkg::NM_W-1:0]            num_medians,
  input  wire                                  pipe_busy,
  input  wire  [pmce_pkg::COST_W-1:0]          acc,
  input  wire                                  out_stall,
  output pmce_pkg::state_t                     state,
  output pmce_pkg::tag_t                       issue,
  output logic [$clog2(MAX_CUSTOMERS)-1:0]     cust,
  output logic [((MAX_MEDIANS > 1) ? $clog2(MAX_MEDIANS) : 1)-1:0] slot,
  output logic                                 out_valid,
  output logic [pmce_pkg::COST_W-1:0]          out_cost
);
  import pmce_pkg::*;

  localparam int CW  = $clog2(MAX_CUSTOMERS);
  localparam int CCW = $clog2(MAX_CUSTOMERS + 1);
  localparam int MW  = (MAX_MEDIANS > 1) ? $clog2(MAX_MEDIANS) : 1;
  localparam int MCW = $clog2(MAX_MEDIANS + 1);

  state_t          state_r, state_nxt;
  logic [CW-1:0]   cust_r, cust_nxt, cust_last_r, cust_last_nxt;
  logic [MW-1:0]   slot_r, slot_nxt, slot_last_r, slot_last_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [COST_W-1:0] out_cost_r;
  logic [CCW-1:0]  nc_lim;
  logic [MCW-1:0]  np_lim;
  logic            nc_zero, slot_end, walk_end, out_free, out_load;

  always_comb begin
    if (32'(num_customers) > 32'(MAX_CUSTOMERS)) begin
      nc_lim = CCW'(MAX_CUSTOMERS);
    end else begin
      nc_lim = CCW'(num_customers);
    end
    if (num_medians == '0) begin
      np_lim = MCW'(1);
    end else if (32'(num_medians) > 32'(MAX_MEDIANS)) begin
      np_lim = MCW'(MAX_MEDIANS);
    end else begin
      np_lim = MCW'(num_medians);
    end
  end

  assign nc_zero  = (num_customers == '0);
  assign slot_end = (slot_r == slot_last_r);
  assign walk_end = slot_end && (cust_r == cust_last_r);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = nc_zero ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (walk_end) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    issue.valid = (state_r == ST_RUN);
    issue.first = (slot_r == '0);
    issue.last  = slot_end;
    out_load    = (state_r == ST_DONE) && out_free;
  end

  always_comb begin
    cust_nxt      = cust_r;
    slot_nxt      = slot_r;
    cust_last_nxt = cust_last_r;
    slot_last_nxt = slot_last_r;
    if (start) begin
      cust_nxt      = '0;
      slot_nxt      = '0;
      cust_last_nxt = CW'(nc_lim - 1'b1);
      slot_last_nxt = MW'(np_lim - 1'b1);
    end else if (state_r == ST_RUN) begin
      if (slot_end) begin
        slot_nxt = '0;
        cust_nxt = cust_r + 1'b1;
      end else begin
        slot_nxt = slot_r + 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cust_r      <= cust_nxt;
    slot_r      <= slot_nxt;
    cust_last_r <= cust_last_nxt;
    slot_last_r <= slot_last_nxt;
    if (out_load) begin
      out_cost_r <= acc;
    end
  end

  assign state     = state_r;
  assign cust      = cust_r;
  assign slot      = slot_r;
  assign out_valid = out_valid_r;
  assign out_cost  = out_cost_r;

endmodule
`default_nettype wire

FILE: hdl/pmce_path.sv
// Datapath: distance lookup, running minimum, weight multiply, accumulate.
// Depends on pmce_pkg; RAMs sit in the top level.
`default_nettype none
module pmce_path #(
  parameter int MAX_CUSTOMERS  = 256,
  parameter int MAX_FACILITIES = 256
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   clear,
  input  wire                                   use_weights,
  input  pmce_pkg::tag_t                        issue,
  input  wire  [$clog2(MAX_CUSTOMERS)-1:0]      cust,
  input  wire  [pmce_pkg::FAC_W-1:0]            med_rdata,
  input  wire  [pmce_pkg::DIST_W-1:0]           dist_rdata,
  input  wire  [pmce_pkg::WGT_W-1:0]            wgt_rdata,
  output logic [$clog2(MAX_CUSTOMERS)+$clog2(MAX_FACILITIES)-1:0] dist_raddr,
  output logic [$clog2(MAX_CUSTOMERS)-1:0]      wgt_raddr,
  output logic [pmce_pkg::COST_W-1:0]           acc,
  output logic                                  busy
);
  import pmce_pkg::*;

  localparam int CW = $clog2(MAX_CUSTOMERS);
  localparam int FW = $clog2(MAX_FACILITIES);

  tag_t              tag_b_r, tag_c_r;
  logic              v_d_r, v_e_r;
  logic [CW-1:0]     cust_b_r;
  logic [DIST_W-1:0] best_r, cand, fin_r;
  logic [WGT_W-1:0]  wfin_r;
  logic [PROD_W-1:0] prod_r;
  logic [COST_W-1:0] acc_r;

  assign dist_raddr = {cust_b_r, FW'(med_rdata)};
  assign wgt_raddr  = cust_b_r;
  assign cand = (tag_c_r.first || (dist_rdata < best_r)) ? dist_rdata : best_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_b_r <= '0;
      tag_c_r <= '0;
      v_d_r   <= 1'b0;
      v_e_r   <= 1'b0;
    end else begin
      tag_b_r <= issue;
      tag_c_r <= tag_b_r;
      v_d_r   <= tag_c_r.valid && tag_c_r.last;
      v_e_r   <= v_d_r;
    end
  end

  always_ff @(posedge clk) begin
    cust_b_r <= cust;
    if (tag_c_r.valid) begin
      best_r <= cand;
    end
    if (tag_c_r.valid && tag_c_r.last) begin
      fin_r  <= cand;
      wfin_r <= wgt_rdata;
    end
    if (v_d_r) begin
      prod_r <= use_weights ? (PROD_W'(fin_r) * PROD_W'(wfin_r)) : PROD_W'(fin_r);
    end
    if (clear) begin
      acc_r <= '0;
    end else if (v_e_r) begin
      acc_r <= acc_r + COST_W'(prod_r);
    end
  end

  assign acc  = acc_r;
  assign busy = tag_b_r.valid || tag_c_r.valid || v_d_r || v_e_r;

endmodule
`default_nettype wire

FILE: hdl/p_median_cost_evaluator_unit.sv
// Median cost evaluator: input, result and register ports; RAMs; assertions.
// Depends on pmce_pkg, pmce_ram, pmce_seq, pmce_path and the assertion header.
//
// Input channel (in_valid / in_stall): one item per transfer. Distance, weight
// and median-slot loads write one RAM entry each, are taken one per cycle and
// give no result. An evaluate item gives one cost on the output channel.
// Evaluate walks num_customers x num_medians entries, one per cycle, through the
// shared compare / multiply / accumulate pipeline fed by the distance RAM read
// port, then drains four stages. A zero customer count returns 0 without a
// walk. in_stall is high for the whole walk. The result sits in an output
// register (out_valid / out_stall); loads are taken while it waits, and a
// further evaluate finishes its walk then holds until the register frees.
// cfg_ready is always high; the user must see that registers are written
// only while idle, as the block does not enforce it. Reset (rst_n low,
// synchronous) returns to idle, empties the output and sets 256 customers,
// 16 medians, weighted mode. RAM contents are undefined until loaded.
`default_nettype none
module p_median_cost_evaluator_unit #(
  parameter int MAX_CUSTOMERS  = 256,
  parameter int MAX_FACILITIES = 256,
  parameter int MAX_MEDIANS    = 16
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire  [pmce_pkg::ACT_W-1:0]         in_action,
  input  wire  [pmce_pkg::CUST_W-1:0]        in_customer,
  input  wire  [pmce_pkg::FAC_W-1:0]         in_facility,
  input  wire  [pmce_pkg::SLOT_W-1:0]        in_slot,
  input  wire  [pmce_pkg::DIST_W-1:0]        in_distance,
  input  wire  [pmce_pkg::WGT_W-1:0]         in_weight,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic [pmce_pkg::COST_W-1:0]        out_cost,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [pmce_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [pmce_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import pmce_pkg::*;

  localparam int CW = $clog2(MAX_CUSTOMERS);
  localparam int FW = $clog2(MAX_FACILITIES);
  localparam int MW = (MAX_MEDIANS > 1) ? $clog2(MAX_MEDIANS) : 1;

  logic [NC_W-1:0]   num_customers_r;
  logic [NM_W-1:0]   num_medians_r;
  logic              use_weights_r;
  logic              in_xfer, start, pipe_busy;
  logic              dist_we, wgt_we, med_we;
  state_t            state;
  tag_t              issue;
  logic [CW-1:0]     cust, wgt_raddr;
  logic [MW-1:0]     slot;
  logic [CW+FW-1:0]  dist_raddr;
  logic [FAC_W-1:0]  med_rdata;
  logic [DIST_W-1:0] dist_rdata;
  logic [WGT_W-1:0]  wgt_rdata;
  logic [COST_W-1:0] acc;

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && !in_stall;
  assign start     = in_xfer && (in_action == ACT_EVAL);

  assign dist_we = in_xfer && (in_action == ACT_LOAD_DIST)
                   && (32'(in_customer) < 32'(MAX_CUSTOMERS))
                   && (32'(in_facility) < 32'(MAX_FACILITIES));
  assign wgt_we  = in_xfer && (in_action == ACT_LOAD_WEIGHT)
                   && (32'(in_customer) < 32'(MAX_CUSTOMERS));
  assign med_we  = in_xfer && (in_action == ACT_LOAD_MEDIAN)
                   && (32'(in_slot) < 32'(MAX_MEDIANS))
                   && (32'(in_facility) < 32'(MAX_FACILITIES));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_customers_r <= NC_W'(256);
      num_medians_r   <= NM_W'(16);
      use_weights_r   <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NUM_CUSTOMERS: num_customers_r <= cfg_data[NC_W-1:0];
        CFG_NUM_MEDIANS:   num_medians_r   <= cfg_data[NM_W-1:0];
        CFG_USE_WEIGHTS:   use_weights_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  pmce_ram #(.WIDTH(DIST_W), .DEPTH(1 << (CW + FW))) u_dist_ram (
    .clk     (clk),
    .wr_en   (dist_we),
    .wr_addr ({CW'(in_customer), FW'(in_facility)}),
    .wr_data (in_distance),
    .rd_addr (dist_raddr),
    .rd_data (dist_rdata)
  );

  pmce_ram #(.WIDTH(WGT_W), .DEPTH(MAX_CUSTOMERS)) u_wgt_ram (
    .clk     (clk),
    .wr_en   (wgt_we),
    .wr_addr (CW'(in_customer)),
    .wr_data (in_weight),
    .rd_addr (wgt_raddr),
    .rd_data (wgt_rdata)
  );

  pmce_ram #(.WIDTH(FAC_W), .DEPTH(MAX_MEDIANS)) u_med_ram (
    .clk     (clk),
    .wr_en   (med_we),
    .wr_addr (MW'(in_slot)),
    .wr_data (in_facility),
    .rd_addr (slot),
    .rd_data (med_rdata)
  );

  pmce_seq #(.MAX_CUSTOMERS(MAX_CUSTOMERS), .MAX_MEDIANS(MAX_MEDIANS)) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .num_customers (num_customers_r),
    .num_medians   (num_medians_r),
    .pipe_busy     (pipe_busy),
    .acc           (acc),
    .out_stall     (out_stall),
    .state         (state),
    .issue         (issue),
    .cust          (cust),
    .slot          (slot),
    .out_valid     (out_valid),
    .out_cost      (out_cost)
  );

  pmce_path #(.MAX_CUSTOMERS(MAX_CUSTOMERS), .MAX_FACILITIES(MAX_FACILITIES)) u_path (
    .clk         (clk),
    .rst_n       (rst_n),
    .clear       (start),
    .use_weights (use_weights_r),
    .issue       (issue),
    .cust        (cust),
    .med_rdata   (med_rdata),
    .dist_rdata  (dist_rdata),
    .wgt_rdata   (wgt_rdata),
    .dist_raddr  (dist_raddr),
    .wgt_raddr   (wgt_raddr),
    .acc         (acc),
    .busy        (pipe_busy)
  );

`include "p_median_cost_evaluator_unit_assert.svh"

  `PMCE_ASSERT_ALWAYS(a_idle_pipe_empty, in_stall || !pipe_busy)
  `PMCE_ASSERT_ALWAYS(a_out_from_done, !$rose(out_valid) || $past(state == ST_DONE))
  `PMCE_ASSERT_NEXT(a_eval_blocks, in_valid && !in_stall && in_action == ACT_EVAL, in_stall)

endmodule
`default_nettype wire
